// ===== design/efe_pkg.sv =====
// shared types, constants and the crc-16 step function of the escaped frame encoder
package efe_pkg;

  // field widths
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CRC_W  = 16;

  // crc-16/ccitt-false seed
  localparam logic [CRC_W-1:0] CRC_SEED = 16'hFFFF;

  // register defaults
  localparam logic [BYTE_W-1:0] ESCAPE_RESET = 8'd92;
  localparam logic [BYTE_W-1:0] END_RESET    = 8'd0;

  // configuration register indexes
  localparam int unsigned      CFG_IDX_W      = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_END    = 1'b1;

  // default depth of the job queue between front and back
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // one classified item as handed from front to back
  typedef struct packed {
    logic [BYTE_W-1:0] cmd;
    logic [BYTE_W-1:0] data;
    logic              first;
    logic              last;
    logic              add_crc;   // already qualified with last
    logic              data_dup;  // payload byte equals escape code
    logic              hi_dup;    // crc high byte equals escape code
    logic              lo_dup;    // crc low byte equals escape code
    logic [CRC_W-1:0]  crc;       // crc after this payload byte
  } efe_job_t;

  // output sequencer steps
  typedef enum logic [10:0] {
    ST_START     = 11'b000_0000_0001,
    ST_OPEN      = 11'b000_0000_0010,
    ST_CMD       = 11'b000_0000_0100,
    ST_DATA      = 11'b000_0000_1000,
    ST_DATA_DUP  = 11'b000_0001_0000,
    ST_CRC_HI    = 11'b000_0010_0000,
    ST_HI_DUP    = 11'b000_0100_0000,
    ST_CRC_LO    = 11'b000_1000_0000,
    ST_LO_DUP    = 11'b001_0000_0000,
    ST_CLOSE_ESC = 11'b010_0000_0000,
    ST_CLOSE_END = 11'b100_0000_0000
  } efe_step_t;

  // one byte of crc-16 (poly 0x1021, msb first, no reflection)
  function automatic logic [CRC_W-1:0] crc16_update(input logic [CRC_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] byte_in);
    logic [CRC_W-1:0] c;
    c = {crc[7:0], crc[15:8]};
    c = c ^ {8'h00, byte_in};
    c = c ^ {12'h000, c[7:4]};
    c = c ^ {c[3:0], 12'h000};
    c = c ^ {3'b000, c[7:0], 5'b00000};
    return c;
  endfunction

endpackage

// ===== design/efe_front.sv =====
// front part: accepts input transactions, runs the crc and classifies the job
module efe_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [efe_pkg::BYTE_W-1:0]   cmd_code,
  input  logic [efe_pkg::BYTE_W-1:0]   data_byte,
  input  logic                         first,
  input  logic                         last,
  input  logic                         add_crc,
  input  logic [efe_pkg::BYTE_W-1:0]   escape_code,
  input  logic                         q_full,
  output logic                         q_push,
  output efe_pkg::efe_job_t            q_job
);

  logic [efe_pkg::CRC_W-1:0] crc_r;
  logic [efe_pkg::CRC_W-1:0] crc_nxt;
  logic [efe_pkg::CRC_W-1:0] crc_base;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // crc after this byte, reseeded on a first byte
  assign crc_base = first ? efe_pkg::CRC_SEED : crc_r;
  assign crc_nxt  = efe_pkg::crc16_update(crc_base, data_byte);

  // classify the item for the back part
  always_comb begin
    q_job          = '0;
    q_job.cmd      = cmd_code;
    q_job.data     = data_byte;
    q_job.first    = first;
    q_job.last     = last;
    q_job.add_crc  = add_crc && last;
    q_job.data_dup = (data_byte == escape_code);
    q_job.hi_dup   = (crc_nxt[15:8] == escape_code);
    q_job.lo_dup   = (crc_nxt[7:0] == escape_code);
    q_job.crc      = crc_nxt;
  end

  // running crc of the current frame
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= efe_pkg::CRC_SEED;
    end else if (q_push) begin
      crc_r <= crc_nxt;
    end
  end

endmodule

// ===== design/efe_queue.sv =====
// short job queue between front and back
module efe_queue #(
  parameter int unsigned QUEUE_DEPTH = efe_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  efe_pkg::efe_job_t push_job,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output efe_pkg::efe_job_t head_job
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  efe_pkg::efe_job_t slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [PTR_W-1:0]  wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_nxt;
  logic              do_push;
  logic              do_pop;

  assign full     = (cnt_r == FULL_CNT);
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_job = slot_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // job storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ===== design/efe_back.sv =====
// back part: steps through the bytes of the head job into the output register
module efe_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_empty,
  input  efe_pkg::efe_job_t           head_job,
  output logic                        q_pop,
  input  logic [efe_pkg::BYTE_W-1:0]  escape_code,
  input  logic [efe_pkg::BYTE_W-1:0]  end_code,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [efe_pkg::BYTE_W-1:0]  out_byte,
  output logic                        run_last,
  output logic                        frame_done
);

  efe_pkg::efe_step_t step_r;
  efe_pkg::efe_step_t step_cur;
  efe_pkg::efe_step_t step_nxt;
  logic                        fin;
  logic [efe_pkg::BYTE_W-1:0]  byte_cur;
  logic                        load;

  logic                        out_valid_r;
  logic [efe_pkg::BYTE_W-1:0]  out_byte_r;
  logic                        run_last_r;
  logic                        frame_done_r;

  // a fresh head job starts at the opening or at its payload byte
  always_comb begin
    if (step_r == efe_pkg::ST_START) begin
      step_cur = head_job.first ? efe_pkg::ST_OPEN : efe_pkg::ST_DATA;
    end else begin
      step_cur = step_r;
    end
  end

  // byte of the current step and the step after it
  always_comb begin
    byte_cur = head_job.data;
    step_nxt = efe_pkg::ST_START;
    fin      = 1'b0;
    case (step_cur)
      efe_pkg::ST_OPEN: begin
        byte_cur = escape_code;
        step_nxt = efe_pkg::ST_CMD;
      end
      efe_pkg::ST_CMD: begin
        byte_cur = head_job.cmd;
        step_nxt = efe_pkg::ST_DATA;
      end
      efe_pkg::ST_DATA, efe_pkg::ST_DATA_DUP: begin
        byte_cur = head_job.data;
        if (step_cur == efe_pkg::ST_DATA && head_job.data_dup) begin
          step_nxt = efe_pkg::ST_DATA_DUP;
        end else if (!head_job.last) begin
          fin = 1'b1;
        end else if (head_job.add_crc) begin
          step_nxt = efe_pkg::ST_CRC_HI;
        end else begin
          step_nxt = efe_pkg::ST_CLOSE_ESC;
        end
      end
      efe_pkg::ST_CRC_HI: begin
        byte_cur = head_job.crc[15:8];
        step_nxt = head_job.hi_dup ? efe_pkg::ST_HI_DUP : efe_pkg::ST_CRC_LO;
      end
      efe_pkg::ST_HI_DUP: begin
        byte_cur = head_job.crc[15:8];
        step_nxt = efe_pkg::ST_CRC_LO;
      end
      efe_pkg::ST_CRC_LO: begin
        byte_cur = head_job.crc[7:0];
        step_nxt = head_job.lo_dup ? efe_pkg::ST_LO_DUP : efe_pkg::ST_CLOSE_ESC;
      end
      efe_pkg::ST_LO_DUP: begin
        byte_cur = head_job.crc[7:0];
        step_nxt = efe_pkg::ST_CLOSE_ESC;
      end
      efe_pkg::ST_CLOSE_ESC: begin
        byte_cur = escape_code;
        step_nxt = efe_pkg::ST_CLOSE_END;
      end
      efe_pkg::ST_CLOSE_END: begin
        byte_cur = end_code;
        fin      = 1'b1;
      end
      default: begin
        byte_cur = head_job.data;
        step_nxt = efe_pkg::ST_START;
        fin      = 1'b0;
      end
    endcase
  end

  // emit one byte whenever a job is queued and the output register is free or being drained
  assign load  = !q_empty && (!out_valid_r || out_ready);
  assign q_pop = load && fin;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= efe_pkg::ST_START;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        step_r <= fin ? efe_pkg::ST_START : step_nxt;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r   <= byte_cur;
      run_last_r   <= fin;
      frame_done_r <= (step_cur == efe_pkg::ST_CLOSE_END);
    end
  end

  assign out_valid  = out_valid_r;
  assign out_byte   = out_byte_r;
  assign run_last   = run_last_r;
  assign frame_done = frame_done_r;

endmodule

// ===== design/escaped_frame_encoder_crc16_unit.sv =====
// top level of the escaped frame encoder with crc-16/ccitt-false
//
// channel | direction | handshake          | payload
// --------+-----------+--------------------+-------------------------------------------
// in_     | slave     | in_tvalid/tready   | tdata cmd_code,data_byte; tuser first,add_crc
// out_    | master    | out_tvalid/tready  | tdata out_byte; tlast run_last; tuser frame_done
// cfg_    | slave     | cfg_valid/ready    | cfg_index, cfg_data (always ready)
//
// one output byte per cycle while a job is queued and out_tready is high; an item causes
// 1 byte for a plain byte, 2 when stuffed, up to 10 at frame edges, set by the back sequencer.
// the front takes one item per cycle while the job queue (QUEUE_DEPTH entries) has room.
// the output register holds its byte while out_tready is low; the queue absorbs the front.
// synchronous active-low reset clears the queue, sequencer, crc (0xffff) and output valid, and loads config defaults.
module escaped_frame_encoder_crc16_unit #(
  parameter int unsigned QUEUE_DEPTH = efe_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [15:0]                   in_tdata,   // [7:0] cmd_code, [15:8] data_byte
  input  logic                          in_tlast,   // last
  input  logic [1:0]                    in_tuser,   // [0] first, [1] add_crc
  // result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [7:0]                    out_tdata,  // [7:0] out_byte
  output logic                          out_tlast,  // run_last
  output logic                          out_tuser,  // [0] frame_done
  // configuration writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [efe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [efe_pkg::BYTE_W-1:0]    cfg_data
);

  logic [efe_pkg::BYTE_W-1:0] escape_code_r;
  logic [efe_pkg::BYTE_W-1:0] end_code_r;
  logic                       q_full;
  logic                       q_empty;
  logic                       q_push;
  logic                       q_pop;
  efe_pkg::efe_job_t          q_job;
  efe_pkg::efe_job_t          head_job;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      escape_code_r <= efe_pkg::ESCAPE_RESET;
      end_code_r    <= efe_pkg::END_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        efe_pkg::CFG_ESCAPE: escape_code_r <= cfg_data;
        efe_pkg::CFG_END:    end_code_r    <= cfg_data;
        default: begin
          escape_code_r <= escape_code_r;
        end
      endcase
    end
  end

  // accept and classify
  efe_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .cmd_code    (in_tdata[7:0]),
    .data_byte   (in_tdata[15:8]),
    .first       (in_tuser[0]),
    .last        (in_tlast),
    .add_crc     (in_tuser[1]),
    .escape_code (escape_code_r),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_job       (q_job)
  );

  // job queue
  efe_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head_job (head_job)
  );

  // byte sequencer and output register
  efe_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (q_empty),
    .head_job    (head_job),
    .q_pop       (q_pop),
    .escape_code (escape_code_r),
    .end_code    (end_code_r),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_byte    (out_tdata),
    .run_last    (out_tlast),
    .frame_done  (out_tuser)
  );

endmodule
